@@ hw/rtl/rfw_pkg.sv @@
package rfw_pkg;

	// status bit positions: N V M X D I Z C
	localparam logic [7:0] FLAG_C = 8'h01;
	localparam logic [7:0] FLAG_Z = 8'h02;
	localparam logic [7:0] FLAG_X = 8'h10;
	localparam logic [7:0] FLAG_M = 8'h20;
	localparam logic [7:0] FLAG_N = 8'h80;

	localparam logic [7:0] EMU_STACK_PAGE  = 8'h01;
	localparam logic [7:0] INIT_CLEAR_MASK = 8'h0f;

	// reset comes up in emulation with C cleared, then the low status bits cleared
	localparam logic [7:0]  STATUS_RESET = 8'h00 & ~(INIT_CLEAR_MASK | FLAG_C);
	localparam logic [15:0] STACK_RESET  = {EMU_STACK_PAGE, 8'h00};

	typedef enum logic [3:0] {
		ACT_NONE      = 4'd0,
		ACT_WRITE_A   = 4'd1,
		ACT_WRITE_A16 = 4'd2,
		ACT_WRITE_X   = 4'd3,
		ACT_WRITE_Y   = 4'd4,
		ACT_WRITE_DP  = 4'd5,
		ACT_WRITE_SP  = 4'd6,
		ACT_WRITE_PC  = 4'd7,
		ACT_INC_PC    = 4'd8,
		ACT_WRITE_PB  = 4'd9,
		ACT_WRITE_DB  = 4'd10,
		ACT_FORCE_P   = 4'd11,
		ACT_SET_P     = 4'd12,
		ACT_CLEAR_P   = 4'd13,
		ACT_ENTER_EMU = 4'd14,
		ACT_LEAVE_EMU = 4'd15
	} rfw_action_t;

	typedef struct packed {
		logic [15:0] acc;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] page;
		logic [15:0] stack;
		logic [15:0] pc;
		logic [7:0]  pbank;
		logic [7:0]  dbank;
		logic [7:0]  status;
		logic        emu;
		logic        acc_narrow;
		logic        index_narrow;
	} rfw_regs_t;

	typedef struct packed {
		rfw_action_t action;
		logic [15:0] value;
		logic [7:0]  flag_mask;
	} rfw_req_t;

	localparam int REGS_W  = $bits(rfw_regs_t);
	localparam int OUT_W   = ((REGS_W + 7) / 8) * 8;
	localparam int REQ_W   = 4 + 16 + 8;
	localparam int IN_W    = ((REQ_W + 7) / 8) * 8;

	function automatic logic [7:0] nz8(input logic [7:0] status, input logic [7:0] v);
		logic [7:0] s;
		s = status & ~(FLAG_Z | FLAG_N);
		if (v == 8'h00) s = s | FLAG_Z;
		if (v[7]) s = s | FLAG_N;
		return s;
	endfunction

	function automatic logic [7:0] nz16(input logic [7:0] status, input logic [15:0] v);
		logic [7:0] s;
		s = status & ~(FLAG_Z | FLAG_N);
		if (v == 16'h0000) s = s | FLAG_Z;
		if (v[15]) s = s | FLAG_N;
		return s;
	endfunction

endpackage

@@ hw/rtl/rfw_exec.sv @@
module rfw_exec (
	input  rfw_pkg::rfw_req_t  req,
	input  rfw_pkg::rfw_regs_t cur,
	output rfw_pkg::rfw_regs_t nxt
);
	import rfw_pkg::*;

	logic [7:0] lo;

	assign lo = req.value[7:0];

	always_comb begin
		nxt = cur;
		case (req.action)
			ACT_NONE: begin
			end
			ACT_WRITE_A: begin
				if (cur.acc_narrow) begin
					nxt.acc    = {cur.acc[15:8], lo};
					nxt.status = nz8(cur.status, lo);
				end else begin
					nxt.acc    = req.value;
					nxt.status = nz16(cur.status, req.value);
				end
			end
			ACT_WRITE_A16: begin
				nxt.acc    = req.value;
				nxt.status = nz16(cur.status, req.value);
			end
			ACT_WRITE_X: begin
				if (cur.index_narrow) begin
					nxt.x      = {8'h00, lo};
					nxt.status = nz8(cur.status, lo);
				end else begin
					nxt.x      = req.value;
					nxt.status = nz16(cur.status, req.value);
				end
			end
			ACT_WRITE_Y: begin
				if (cur.index_narrow) begin
					nxt.y      = {8'h00, lo};
					nxt.status = nz8(cur.status, lo);
				end else begin
					nxt.y      = req.value;
					nxt.status = nz16(cur.status, req.value);
				end
			end
			ACT_WRITE_DP: begin
				nxt.page   = req.value;
				nxt.status = nz16(cur.status, req.value);
			end
			ACT_WRITE_SP: nxt.stack = req.value;
			ACT_WRITE_PC: nxt.pc = req.value;
			ACT_INC_PC:   nxt.pc = cur.pc + 16'd1;
			ACT_WRITE_PB: nxt.pbank = lo;
			ACT_WRITE_DB: begin
				nxt.dbank  = lo;
				nxt.status = nz8(cur.status, lo);
			end
			ACT_FORCE_P, ACT_SET_P: begin
				nxt.status = (req.action == ACT_FORCE_P) ? req.flag_mask
					: (cur.status | req.flag_mask);
				// set X or M bits narrow the widths, clear ones leave them
				if ((req.flag_mask & FLAG_X) != 8'h00) begin
					nxt.index_narrow = 1'b1;
					nxt.x            = {8'h00, cur.x[7:0]};
					nxt.y            = {8'h00, cur.y[7:0]};
				end
				if ((req.flag_mask & FLAG_M) != 8'h00) nxt.acc_narrow = 1'b1;
			end
			ACT_CLEAR_P: begin
				nxt.status = cur.status & ~req.flag_mask;
				if ((req.flag_mask & FLAG_X) != 8'h00) nxt.index_narrow = 1'b0;
				if ((req.flag_mask & FLAG_M) != 8'h00) nxt.acc_narrow = 1'b0;
			end
			ACT_ENTER_EMU: begin
				nxt.emu          = 1'b1;
				nxt.status       = cur.status & ~FLAG_C;
				nxt.stack        = {EMU_STACK_PAGE, cur.stack[7:0]};
				nxt.index_narrow = 1'b1;
				nxt.x            = {8'h00, cur.x[7:0]};
				nxt.y            = {8'h00, cur.y[7:0]};
				nxt.acc_narrow   = 1'b1;
			end
			ACT_LEAVE_EMU: begin
				nxt.emu          = 1'b0;
				nxt.status       = cur.status | FLAG_C | FLAG_X | FLAG_M;
				nxt.index_narrow = 1'b1;
				nxt.x            = {8'h00, cur.x[7:0]};
				nxt.y            = {8'h00, cur.y[7:0]};
				nxt.acc_narrow   = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/cpu_register_file_width_modes.sv @@
// path: a request accepted into the input register moves on to the result register,
// where it is offered as a result
// throughput: one request per cycle, sustained while the result side keeps up
// the input register refills in the same cycle that its request moves to the result register
// reset: asynchronous, active low; registers come up as after entering emulation,
// both widths narrow, stack 0x0100, status zero, no request or result pending
module cpu_register_file_width_modes (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// action[3:0], value[19:4], flag_mask[27:20], zero pad
	input  logic [rfw_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// acc_value[15:0], x_value[31:16], y_value[47:32], page_base[63:48],
	// stack_value[79:64], prog_count[95:80], prog_bank[103:96],
	// data_bank_value[111:104], status_bits[119:112], emu_mode[120],
	// acc_narrow[121], index_narrow[122], zero pad
	output logic [rfw_pkg::OUT_W-1:0]   m_tdata
);
	import rfw_pkg::*;

	// input stage
	logic      s1_valid_q;
	rfw_req_t  req_s1;

	// architectural registers
	rfw_regs_t state_q;
	rfw_regs_t state_nxt;

	// result register
	logic      out_valid_q;
	rfw_regs_t result_q;

	logic      advance;
	logic      in_fire;
	rfw_req_t  req_in;

	// the input request moves on when the result register is empty or being drained
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign in_fire  = s_tvalid && s_tready;

	// unpack from the lowest bit up
	always_comb begin
		req_in.action    = rfw_action_t'(s_tdata[3:0]);
		req_in.value     = s_tdata[19:4];
		req_in.flag_mask = s_tdata[27:20];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1 <= req_in;
		end
	end

	// one pass of decode and flag logic per request
	rfw_exec u_exec (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.acc          <= 16'h0000;
			state_q.x            <= 16'h0000;
			state_q.y            <= 16'h0000;
			state_q.page         <= 16'h0000;
			state_q.stack        <= STACK_RESET;
			state_q.pc           <= 16'h0000;
			state_q.pbank        <= 8'h00;
			state_q.dbank        <= 8'h00;
			state_q.status       <= STATUS_RESET;
			state_q.emu          <= 1'b1;
			state_q.acc_narrow   <= 1'b1;
			state_q.index_narrow <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result carries the register file after the update
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= state_nxt;
		end
	end

	assign m_tvalid = out_valid_q;

	always_comb begin
		m_tdata          = '0;
		m_tdata[15:0]    = result_q.acc;
		m_tdata[31:16]   = result_q.x;
		m_tdata[47:32]   = result_q.y;
		m_tdata[63:48]   = result_q.page;
		m_tdata[79:64]   = result_q.stack;
		m_tdata[95:80]   = result_q.pc;
		m_tdata[103:96]  = result_q.pbank;
		m_tdata[111:104] = result_q.dbank;
		m_tdata[119:112] = result_q.status;
		m_tdata[120]     = result_q.emu;
		m_tdata[121]     = result_q.acc_narrow;
		m_tdata[122]     = result_q.index_narrow;
	end

	// narrow index mode never leaves a high byte in X or Y
	a_index_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.index_narrow |-> (state_q.x[15:8] == 8'h00 && state_q.y[15:8] == 8'h00))
		else $error("index high byte set while narrow");

	// a freshly loaded result matches the register file it came from
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (result_q == state_q && out_valid_q))
		else $error("result register out of step with register file");

	// entering emulation pins the stack to page one
	a_enter_emu_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_s1.action == ACT_ENTER_EMU) |=>
		(state_q.stack[15:8] == EMU_STACK_PAGE && state_q.emu && state_q.acc_narrow))
		else $error("emulation entry did not set stack page");

	// an empty result register never holds off the input side
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with result register empty");

endmodule
